// File: rtl/core/nci_pkg.sv
// shared widths, status codes and saturation helper for the cubic newton interpolator
// used by nci_qmul and newton_cubic_interpolator; no dependencies
package nci_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NODES     = 4;
  localparam int XW        = 32;              // node and query width
  localparam int W         = 48;              // intermediate width
  localparam int DW        = W + FRAC_BITS;   // dividend width

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_COIN = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic signed [W-1:0] val;
    logic                sat;
  } sat_res_t;

  // clamp a value one bit wider than the intermediate width
  function automatic sat_res_t sat_w(input logic signed [W:0] v);
    sat_res_t r;
    r.sat = v[W] ^ v[W-1];
    if (!r.sat) begin
      r.val = v[W-1:0];
    end else if (v[W]) begin
      r.val = {1'b1, {(W-1){1'b0}}};
    end else begin
      r.val = {1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/nci_qmul.sv
// pipelined fixed-point multiply, four stages, saturating to the intermediate width
// depends on nci_pkg
module nci_qmul (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [nci_pkg::W-1:0] a,
  input  logic signed [nci_pkg::W-1:0] b,
  output logic signed [nci_pkg::W-1:0] p,
  output logic                         sat
);
  import nci_pkg::*;

  localparam int H  = W / 2;
  localparam int MW = 2 * W - FRAC_BITS;

  logic [W-1:0]   ua, ub;
  logic           neg1, neg2, neg3;
  logic [2*H-1:0] p00, p01, p10, p11;
  logic [2*W-1:0] sum;
  logic [MW-1:0]  mag;
  logic           ovf;

  assign mag = sum[2*W-1:FRAC_BITS];
  assign ovf = neg3 ? ((|mag[MW-1:W]) || (mag[W-1] && (|mag[W-2:0])))
                    : (|mag[MW-1:W-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[W-1] ^ b[W-1];
      ua   <= a[W-1] ? W'(-a) : W'(a);
      ub   <= b[W-1] ? W'(-b) : W'(b);
      neg2 <= neg1;
      p00  <= ua[H-1:0] * ub[H-1:0];
      p01  <= ua[H-1:0] * ub[W-1:H];
      p10  <= ua[W-1:H] * ub[H-1:0];
      p11  <= ua[W-1:H] * ub[W-1:H];
      neg3 <= neg2;
      sum  <= {p11, p00} + {{H{1'b0}}, p01, {H{1'b0}}} + {{H{1'b0}}, p10, {H{1'b0}}};
      sat  <= ovf;
      if (ovf) begin
        p <= neg3 ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        p <= neg3 ? W'(-mag[W-1:0]) : mag[W-1:0];
      end
    end
  end

endmodule

// File: rtl/core/newton_cubic_interpolator.sv
// cubic newton divided-difference interpolator, top level
// depends on nci_pkg and nci_qmul
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-------------------------------------
//  s_*     | in  | s_tvalid / s_tready       | s_tdata: query_x
//  m_*     | out | m_tvalid / m_tready       | m_tdata: interp_value, status, pad
//  apb     | in  | psel/penable/pwrite/pready| node_x0..3, node_y0..3 at 4*i
//
// one query per cycle while m_tready and the sequencer allow; m_tvalid
// follows the s transfer through the node offsets, three chained four-stage
// multipliers, the last sum and the output clamp.
// divided differences depend only on the nodes and are rebuilt by a
// bit-serial divider after reset and after every register write, with
// s_tready low while it runs. rst is synchronous.
// a stall on m_tready freezes the whole pipe, so nothing is lost or repeated.
module newton_cubic_interpolator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] query_x
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] interp_value, [33:32] status, [39:34] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nci_pkg::*;

  localparam int CW    = $clog2(DW) + 1;
  localparam int DEPTH = 15;

  // coefficient sequencer states
  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_START = 3'd1;
  localparam logic [2:0] C_LOAD  = 3'd2;
  localparam logic [2:0] C_DIV   = 3'd3;
  localparam logic [2:0] C_STORE = 3'd4;

  localparam logic [2:0] LAST_STEP = 3'd5;

  // row written by each step of the difference table
  function automatic logic [1:0] step_i(input logic [2:0] s);
    case (s)
      3'd1:    return 2'd1;
      3'd2:    return 2'd2;
      3'd4:    return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  // far node of each step
  function automatic logic [1:0] step_k(input logic [2:0] s);
    case (s)
      3'd0:    return 2'd1;
      3'd1:    return 2'd2;
      3'd2:    return 2'd3;
      3'd3:    return 2'd2;
      default: return 2'd3;
    endcase
  endfunction

  // ---------------- configuration registers ----------------
  logic signed [XW-1:0] cfg_x [NODES];
  logic signed [XW-1:0] cfg_y [NODES];
  logic                 cfg_wr;
  logic [2:0]           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NODES; n++) begin
        cfg_x[n] <= XW'(n) << FRAC_BITS;
        cfg_y[n] <= '0;
      end
    end else if (cfg_wr) begin
      if (cfg_idx[2]) begin
        cfg_y[cfg_idx[1:0]] <= pwdata;
      end else begin
        cfg_x[cfg_idx[1:0]] <= pwdata;
      end
    end
  end

  always_comb begin
    prdata = cfg_idx[2] ? cfg_y[cfg_idx[1:0]] : cfg_x[cfg_idx[1:0]];
  end

  // ---------------- divided-difference sequencer ----------------
  logic [2:0]          cstate;
  logic [2:0]          step;
  logic signed [W-1:0] tab  [NODES];
  logic signed [W-1:0] coef [NODES];
  logic                coin, csat, qneg;
  logic [DW-1:0]       dvd;
  logic [XW:0]         rem, dvs;
  logic [CW-1:0]       cnt;

  logic [1:0]          si, sk;
  sat_res_t            num;
  logic signed [XW:0]  den;
  logic [XW+1:0]       trial;
  logic                qovf;
  logic signed [W-1:0] qval;
  logic                any_coin;

  assign si  = step_i(step);
  assign sk  = step_k(step);
  assign num = sat_w({tab[si + 2'd1][W-1], tab[si + 2'd1]} - {tab[si][W-1], tab[si]});
  assign den = {cfg_x[sk][XW-1], cfg_x[sk]} - {cfg_x[si][XW-1], cfg_x[si]};
  assign trial = {rem, dvd[DW-1]} - {1'b0, dvs};
  assign qovf  = qneg ? ((|dvd[DW-1:W]) || (dvd[W-1] && (|dvd[W-2:0])))
                      : (|dvd[DW-1:W-1]);
  assign qval  = qovf ? (qneg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
                      : (qneg ? W'(-dvd[W-1:0]) : dvd[W-1:0]);
  assign any_coin = (cfg_x[0] == cfg_x[1]) || (cfg_x[0] == cfg_x[2]) ||
                    (cfg_x[0] == cfg_x[3]) || (cfg_x[1] == cfg_x[2]) ||
                    (cfg_x[1] == cfg_x[3]) || (cfg_x[2] == cfg_x[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate <= C_START;
      step   <= '0;
      cnt    <= '0;
      coin   <= 1'b0;
      csat   <= 1'b0;
    end else if (cfg_wr) begin
      cstate <= C_START;
    end else begin
      case (cstate)
        C_START: begin
          for (int n = 0; n < NODES; n++) begin
            tab[n] <= W'(cfg_y[n]);
          end
          coef[0] <= W'(cfg_y[0]);
          coin    <= any_coin;
          csat    <= 1'b0;
          step    <= '0;
          cstate  <= any_coin ? C_IDLE : C_LOAD;
        end
        C_LOAD: begin
          csat   <= csat | num.sat;
          qneg   <= num.val[W-1] ^ den[XW];
          dvd    <= {(num.val[W-1] ? W'(-num.val) : W'(num.val)), {FRAC_BITS{1'b0}}};
          dvs    <= den[XW] ? (XW+1)'(-den) : (XW+1)'(den);
          rem    <= '0;
          cnt    <= '0;
          cstate <= C_DIV;
        end
        C_DIV: begin
          // restoring division, one quotient bit a cycle
          if (!trial[XW+1]) begin
            rem <= trial[XW:0];
            dvd <= {dvd[DW-2:0], 1'b1};
          end else begin
            rem <= {rem[XW-1:0], dvd[DW-1]};
            dvd <= {dvd[DW-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(DW - 1)) begin
            cstate <= C_STORE;
          end
        end
        C_STORE: begin
          tab[si] <= qval;
          csat    <= csat | qovf;
          case (step)
            3'd0:      coef[1] <= qval;
            3'd3:      coef[2] <= qval;
            LAST_STEP: coef[3] <= qval;
            default:   ;
          endcase
          if (step == LAST_STEP) begin
            cstate <= C_IDLE;
          end else begin
            step   <= step + 1'b1;
            cstate <= C_LOAD;
          end
        end
        default: cstate <= C_IDLE;
      endcase
    end
  end

  // ---------------- evaluation pipeline ----------------
  logic                adv, s_fire;
  logic [DEPTH-1:0]    valid;
  logic signed [W-1:0] p1, d1, d2;
  logic signed [W-1:0] d2d [4];
  logic signed [W-1:0] t1, p2, t2, p3, t3;
  logic                st1, sp2, st2, sp3, st3;
  logic signed [W-1:0] a1, a2, a3;
  logic signed [W-1:0] a1d [3];
  logic signed [W-1:0] a2d [3];
  logic                as1, as2, as3;
  logic                as1d [3];
  logic                as2d [3];
  logic signed [XW-1:0] out_val;
  logic [1:0]           out_st;
  logic signed [XW-1:0] qx;
  sat_res_t             sum1, sum2, sum3;
  logic                 fsat;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && (cstate == C_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign m_tvalid = valid[DEPTH-1];
  assign m_tdata  = {6'd0, out_st, out_val};
  assign qx       = s_tdata;

  assign sum1 = sat_w({coef[0][W-1], coef[0]} + {t1[W-1], t1});
  assign sum2 = sat_w({a1d[2][W-1], a1d[2]} + {t2[W-1], t2});
  assign sum3 = sat_w({a2d[2][W-1], a2d[2]} + {t3[W-1], t3});
  assign fsat = (a3[W-1:XW-1] != {(W-XW+1){a3[W-1]}});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[DEPTH-2:0], s_fire};
    end
  end

  // products (x-x0), (x-x0)(x-x1), ... and the terms that use them
  nci_qmul u_m1 (.clk(clk), .en(adv), .a(coef[1]), .b(p1), .p(t1), .sat(st1));
  nci_qmul u_m2 (.clk(clk), .en(adv), .a(p1),      .b(d1), .p(p2), .sat(sp2));
  nci_qmul u_m3 (.clk(clk), .en(adv), .a(coef[2]), .b(p2), .p(t2), .sat(st2));
  nci_qmul u_m4 (.clk(clk), .en(adv), .a(p2), .b(d2d[3]),  .p(p3), .sat(sp3));
  nci_qmul u_m5 (.clk(clk), .en(adv), .a(coef[3]), .b(p3), .p(t3), .sat(st3));

  always_ff @(posedge clk) begin
    if (adv) begin
      // node offsets of the query, sign-extended to the intermediate width
      p1 <= W'(qx) - W'(cfg_x[0]);
      d1 <= W'(qx) - W'(cfg_x[1]);
      d2 <= W'(qx) - W'(cfg_x[2]);
      d2d[0] <= d2;
      for (int n = 1; n < 4; n++) begin
        d2d[n] <= d2d[n-1];
      end
      // running sum, aligned to each term as it leaves its multiplier
      a1  <= sum1.val;
      as1 <= sum1.sat | st1 | sp2;
      a1d[0]  <= a1;
      as1d[0] <= as1;
      a2  <= sum2.val;
      as2 <= as1d[2] | sum2.sat | st2 | sp3;
      a2d[0]  <= a2;
      as2d[0] <= as2;
      for (int n = 1; n < 3; n++) begin
        a1d[n]  <= a1d[n-1];
        as1d[n] <= as1d[n-1];
        a2d[n]  <= a2d[n-1];
        as2d[n] <= as2d[n-1];
      end
      a3  <= sum3.val;
      as3 <= as2d[2] | sum3.sat | st3;
      // output register: zero with ST_COIN for coincident nodes, else final clamp to q16.16
      if (coin) begin
        out_val <= '0;
        out_st  <= ST_COIN;
      end else begin
        if (fsat) begin
          out_val <= a3[W-1] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
        end else begin
          out_val <= a3[XW-1:0];
        end
        out_st <= (fsat || as3 || csat) ? ST_SAT : ST_OK;
      end
    end
  end

endmodule

// File: tb/nci_checker.sv
// checker for the cubic newton interpolator: mirrors the node registers from apb writes,
// predicts each query result and compares it with the m channel; depends on nci_pkg
module nci_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] query_x
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [31:0] interp_value, [33:32] status, [39:34] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import nci_pkg::*;

  localparam longint POS48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint NEG48 = -64'sh0000_7FFF_FFFF_FFFF - 1;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
  } interp_res_t;

  logic [31:0] node_reg [2*NODES];
  interp_res_t expected_q [$];

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clamp48(longint v, inout bit sat);
    if (v > POS48) begin
      sat = 1;
      return POS48;
    end
    if (v < NEG48) begin
      sat = 1;
      return NEG48;
    end
    return v;
  endfunction

  function automatic longint signed_mag(logic [63:0] mag, bit neg, bit ovf, inout bit sat);
    logic [63:0] lim;
    lim = neg ? (64'd1 << 47) : (64'd1 << 47) - 1;
    if (ovf || mag > lim) begin
      sat = 1;
      return neg ? NEG48 : POS48;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // product truncated toward zero, frac bits dropped
  function automatic longint fx_mul(longint a, longint b, inout bit sat);
    logic [127:0] full;
    full = ({64'd0, mag64(a)} * {64'd0, mag64(b)}) >> FRAC_BITS;
    return signed_mag(full[63:0], (a < 0) != (b < 0), |full[127:64], sat);
  endfunction

  // quotient truncated toward zero, den nonzero
  function automatic longint fx_div(longint num, longint den, inout bit sat);
    logic [127:0] q;
    q = ({64'd0, mag64(num)} << FRAC_BITS) / {64'd0, mag64(den)};
    return signed_mag(q[63:0], (num < 0) != (den < 0), q > (128'd1 << 48), sat);
  endfunction

  function automatic interp_res_t interpolate(logic [31:0] qx_bits);
    longint xs [NODES];
    longint dd [NODES];
    longint qx, acc, prod, d;
    bit sat;
    interp_res_t r;
    sat = 0;
    qx = longint'(signed'(qx_bits));
    for (int i = 0; i < NODES; i++) begin
      xs[i] = longint'(signed'(node_reg[i]));
      dd[i] = longint'(signed'(node_reg[NODES+i]));
    end
    for (int j = 1; j < NODES; j++)
      for (int i = 0; i + j < NODES; i++)
        if (xs[i+j] == xs[i]) begin
          r.value = '0;
          r.status = ST_COIN;
          return r;
        end
    acc = dd[0];
    prod = longint'(1) << FRAC_BITS;
    for (int j = 1; j < NODES; j++) begin
      for (int i = 0; i + j < NODES; i++) begin
        d = clamp48(dd[i+1] - dd[i], sat);
        dd[i] = fx_div(d, xs[i+j] - xs[i], sat);
      end
      prod = fx_mul(prod, qx - xs[j-1], sat);
      acc = clamp48(acc + fx_mul(dd[0], prod, sat), sat);
    end
    if (acc > 64'sh7FFF_FFFF) begin
      acc = 64'sh7FFF_FFFF;
      sat = 1;
    end
    if (acc < -64'sh8000_0000) begin
      acc = -64'sh8000_0000;
      sat = 1;
    end
    r.value = acc[31:0];
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign outstanding = expected_q.size();

  always @(posedge clk) begin
    interp_res_t want;
    if (rst) begin
      node_reg[0] <= 32'h0000_0000;
      node_reg[1] <= 32'h0001_0000;
      node_reg[2] <= 32'h0002_0000;
      node_reg[3] <= 32'h0003_0000;
      for (int i = NODES; i < 2*NODES; i++) node_reg[i] <= '0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[4:2] < 2*NODES)
        node_reg[paddr[4:2]] <= pwdata;
      // predict with the registers as they stand before this edge
      if (s_tvalid && s_tready)
        expected_q.push_back(interpolate(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected transfer", 64'(m_tdata), 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[31:0] !== want.value) report("interp_value", m_tdata[31:0], want.value);
          if (m_tdata[33:32] !== want.status) report("status", m_tdata[33:32], want.status);
          if (m_tdata[39:34] !== 6'd0) report("pad", m_tdata[39:34], 64'd0);
        end
      end
    end
  end

endmodule

// File: tb/tb_newton_cubic_interpolator.sv
// top of the cubic newton interpolator testbench: clock, reset, apb node setup and
// query stimulus; depends on nci_pkg, newton_cubic_interpolator and nci_checker
module tb_newton_cubic_interpolator;
  timeunit 1ns;
  timeprecision 1ps;
  import nci_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          outstanding;
  bit          squeeze = 0;   // asks the receiver for one long hold-off

  localparam int Q_ONE = 32'h0001_0000;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  newton_cubic_interpolator dut (.*);

  nci_checker chk (.*);

  // run limit, far above the slowest legal run
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  // receiver: random stall before each transfer, one long hold-off on request
  initial begin
    int w;
    @(negedge rst);
    forever begin
      if (squeeze) begin
        m_tready <= 0;
        repeat (400) @(posedge clk);
        squeeze = 0;
      end
      w = $urandom_range(0, 5);
      if (w > 0) begin
        m_tready <= 0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // one apb write: setup cycle, access cycle, then an idle cycle
  task automatic reg_write(int idx, logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 5'(4 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  // one query transfer after a random gap; valid stays up when the gap is zero
  task automatic send_query(logic [31:0] q);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= q;
    do @(posedge clk); while (!s_tready);
  endtask

  // registers change only with the pipe empty
  task automatic drain;
    s_tvalid <= 0;
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_nodes(logic [31:0] x [4], logic [31:0] y [4]);
    drain();
    for (int i = 0; i < NODES; i++) reg_write(i, x[i]);
    for (int i = 0; i < NODES; i++) reg_write(NODES + i, y[i]);
  endtask

  function automatic logic [31:0] pick_query();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    if (r < 9) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // random node set: mostly well spread abscissas, sometimes wide or coincident
  task automatic random_nodes();
    logic [31:0] x [4];
    logic [31:0] y [4];
    int mode;
    mode = $urandom_range(0, 9);
    x[0] = 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    for (int i = 1; i < NODES; i++)
      x[i] = x[i-1] + 32'($urandom_range(1, 32'h0004_0000)) * (mode[0] ? 1 : -1);
    if (mode == 8) x[$urandom_range(1, 3)] = x[0];
    if (mode == 9) foreach (x[i]) x[i] = $urandom;
    foreach (y[i])
      y[i] = (mode > 6) ? $urandom : 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    load_nodes(x, y);
  endtask

  initial begin
    logic [31:0] x [4];
    logic [31:0] y [4];
    repeat (11) @(posedge clk);
    rst <= 0;

    // reset nodes, all values zero: extremes of the query field
    send_query(32'h0000_0000);
    send_query(32'h7FFF_FFFF);
    send_query(32'h8000_0000);
    send_query(32'hFFFF_FFFF);

    // y = 2^x on integer nodes: exact hits, between nodes and beyond them
    x = '{32'h0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE};
    y = '{Q_ONE, 2 * Q_ONE, 4 * Q_ONE, 8 * Q_ONE};
    load_nodes(x, y);
    send_query(32'h0);
    send_query(2 * Q_ONE);
    send_query(32'h0001_8000);
    send_query(-Q_ONE);
    send_query(32'h0010_0000);
    send_query(32'h7FFF_FFFF);

    // coincident abscissas, first pair and then first with last node
    x = '{Q_ONE, Q_ONE, 2 * Q_ONE, 3 * Q_ONE};
    load_nodes(x, y);
    send_query(32'h0);
    send_query(32'h8000_0000);
    x = '{32'h0, Q_ONE, 2 * Q_ONE, 32'h0};
    load_nodes(x, y);
    send_query(Q_ONE);

    // extreme nodes and values: saturation of quotients and of the result
    x = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF};
    y = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    load_nodes(x, y);
    send_query(32'h0);
    send_query(32'h7FFF_FFFF);
    send_query(32'h8000_0000);
    x = '{32'h0, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003};
    load_nodes(x, y);
    send_query(32'h0);
    send_query(Q_ONE);
    send_query(32'h8000_0000);

    // random node sets with random queries, one of them under a long output hold-off
    for (int p = 0; p < 10; p++) begin
      random_nodes();
      if (p == 3) squeeze = 1;
      repeat (80) send_query(pick_query());
    end

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/nci_pkg.sv
rtl/core/nci_qmul.sv
rtl/core/newton_cubic_interpolator.sv
tb/nci_checker.sv
tb/tb_newton_cubic_interpolator.sv
